[src/sllt_pkg.sv]
// Shared types, constants and helpers for the sorted linked list table.
package sllt_pkg;

   localparam int POOL_SLOTS = 32;
   localparam int IDX_W      = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
   localparam int SLOT_W     = 6;
   localparam int KEY_W      = 32;
   localparam int COUNT_W    = 7;
   localparam int MODE_W     = 3;
   localparam int STATUS_W   = 3;

   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_DELETE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DUMP   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_REINIT = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
   } link_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [KEY_W-1:0] data;
   } key_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      link_type         data;
   } link_wr_type;

   // Link of a slot that has not been written since reset or reinit.
   function automatic link_type default_link(logic [IDX_W-1:0] s);
      link_type d;
      d.valid = (s != IDX_W'(POOL_SLOTS - 1));
      d.idx   = s + IDX_W'(1);
      return d;
   endfunction

endpackage

[src/sllt_mem.sv]
// Key and link memories of the slot pool, with per-slot written bits for the link reset value.
module sllt_mem
   import sllt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               clear,
   input  logic               rd_en,
   input  logic [IDX_W-1:0]   rd_addr,
   input  key_wr_type         key_wr,
   input  link_wr_type        link_wr,
   output logic [KEY_W-1:0]   key_q,
   output link_type           link_q
);

   logic [KEY_W-1:0]  key_mem  [POOL_SLOTS];
   link_type          link_mem [POOL_SLOTS];
   logic [POOL_SLOTS-1:0] written_ff;

   logic [KEY_W-1:0]  key_q_ff;
   link_type          link_raw_ff;
   logic [IDX_W-1:0]  addr_q_ff;
   logic              wr_q_ff;

   always_ff @(posedge clock) begin
      if (key_wr.en) begin
         key_mem[key_wr.addr] <= key_wr.data;
      end
      if (rd_en) begin
         key_q_ff <= key_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (link_wr.en) begin
         link_mem[link_wr.addr] <= link_wr.data;
      end
      if (rd_en) begin
         link_raw_ff <= link_mem[rd_addr];
         addr_q_ff   <= rd_addr;
         wr_q_ff     <= written_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         written_ff <= '0;
      end else if (link_wr.en) begin
         written_ff[link_wr.addr] <= 1'b1;
      end
   end

   assign key_q  = key_q_ff;
   assign link_q = wr_q_ff ? link_raw_ff : default_link(addr_q_ff);

endmodule

[src/sorted_linked_list_table.sv]
// Sorted linked list table: ordered key list over a slot pool with a free list.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_mode, req_key
//   rsp      out        rsp_valid/rsp_stall  rsp_status, rsp_slot, rsp_key_out, rsp_count, rsp_last
//
// Insert, delete and search walk the list one slot per cycle through the memory read
// port, then pass S_DONE, S_FREE/S_LINKP (insert) or S_UNLINK/S_RETURN (delete), and S_EMIT.
// Dump emits one result per cycle while rsp is not stalled. Reinit and unused modes go to S_EMIT.
// Synchronous reset empties the list and restores the free chain at once (written bits).
// A stalled rsp holds its transaction; a new req is taken as soon as the sequencer is idle.
module sorted_linked_list_table
   import sllt_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [MODE_W-1:0]          req_mode,
   input  logic signed [KEY_W-1:0]    req_key,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [SLOT_W-1:0]          rsp_slot,
   output logic signed [KEY_W-1:0]    rsp_key_out,
   output logic [COUNT_W-1:0]         rsp_count,
   output logic                       rsp_last
);

   typedef enum logic [3:0] {
      S_IDLE, S_WALK, S_DONE, S_FREE, S_LINKP, S_UNLINK, S_RETURN, S_DUMP, S_EMIT
   } state_type;

   state_type               state_ff;
   logic [MODE_W-1:0]       mode_ff;
   logic [KEY_W-1:0]        key_ff;
   logic [IDX_W-1:0]        head_ff;
   logic                    head_valid_ff;
   logic [IDX_W-1:0]        free_head_ff;
   logic                    free_valid_ff;
   logic [COUNT_W-1:0]      count_ff;
   logic [IDX_W-1:0]        cur_ff;
   logic                    cur_ok_ff;
   logic [IDX_W-1:0]        prev_ff;
   logic                    prev_ok_ff;
   logic                    hit_ff;
   link_type                cur_link_ff;
   logic [IDX_W-1:0]        new_ff;
   logic [STATUS_W-1:0]     res_status_ff;
   logic [SLOT_W-1:0]       res_slot_ff;
   logic [KEY_W-1:0]        res_key_ff;

   logic                    rsp_valid_ff;
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic [SLOT_W-1:0]       rsp_slot_ff;
   logic [KEY_W-1:0]        rsp_key_ff;
   logic [COUNT_W-1:0]      rsp_count_ff;
   logic                    rsp_last_ff;

   logic                    accept;
   logic                    out_free;
   logic                    rsp_load;
   logic                    key_below;

   logic                    rd_en;
   logic [IDX_W-1:0]        rd_addr;
   key_wr_type              key_wr;
   link_wr_type             link_wr;
   logic                    mem_clear;
   logic [KEY_W-1:0]        key_q;
   link_type                link_q;

   sllt_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .clear   (mem_clear),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .key_wr  (key_wr),
      .link_wr (link_wr),
      .key_q   (key_q),
      .link_q  (link_q)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = out_free && (state_ff == S_EMIT || state_ff == S_DUMP);
   assign key_below = $signed(key_q) < $signed(key_ff);
   assign mem_clear = accept && (req_mode == MODE_REINIT);

   // Memory port control.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = head_ff;
      key_wr  = '0;
      link_wr = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept && head_valid_ff &&
                (req_mode == MODE_DELETE || req_mode == MODE_SEARCH ||
                 req_mode == MODE_DUMP ||
                 (req_mode == MODE_INSERT && free_valid_ff))) begin
               rd_en = 1'b1;
            end
         end
         S_WALK: begin
            rd_addr = link_q.idx;
            rd_en   = key_below && link_q.valid;
         end
         S_DONE: begin
            rd_addr = free_head_ff;
            rd_en   = (mode_ff == MODE_INSERT) && !hit_ff;
         end
         S_FREE: begin
            key_wr.en          = 1'b1;
            key_wr.addr        = free_head_ff;
            key_wr.data        = key_ff;
            link_wr.en         = 1'b1;
            link_wr.addr       = free_head_ff;
            link_wr.data.valid = cur_ok_ff;
            link_wr.data.idx   = cur_ff;
         end
         S_LINKP: begin
            link_wr.en         = 1'b1;
            link_wr.addr       = prev_ff;
            link_wr.data.valid = 1'b1;
            link_wr.data.idx   = new_ff;
         end
         S_UNLINK: begin
            link_wr.en   = prev_ok_ff;
            link_wr.addr = prev_ff;
            link_wr.data = cur_link_ff;
         end
         S_RETURN: begin
            link_wr.en         = 1'b1;
            link_wr.addr       = cur_ff;
            link_wr.data.valid = free_valid_ff;
            link_wr.data.idx   = free_head_ff;
         end
         S_DUMP: begin
            rd_addr = link_q.idx;
            rd_en   = out_free && link_q.valid;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         head_valid_ff <= 1'b0;
         free_head_ff  <= '0;
         free_valid_ff <= 1'b1;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  mode_ff       <= req_mode;
                  key_ff        <= req_key;
                  cur_ff        <= head_ff;
                  cur_ok_ff     <= head_valid_ff;
                  prev_ff       <= '0;
                  prev_ok_ff    <= 1'b0;
                  hit_ff        <= 1'b0;
                  res_slot_ff   <= '0;
                  case (req_mode)
                     MODE_INSERT, MODE_DELETE, MODE_SEARCH: begin
                        res_key_ff <= req_key;
                        if (req_mode == MODE_INSERT && !free_valid_ff) begin
                           res_status_ff <= ST_FULL;
                           state_ff      <= S_EMIT;
                        end else begin
                           res_status_ff <= ST_OK;
                           if (head_valid_ff) begin
                              state_ff <= S_WALK;
                           end else begin
                              state_ff <= S_DONE;
                           end
                        end
                     end
                     MODE_DUMP: begin
                        // status and key only reach rsp when the list is empty
                        res_status_ff <= ST_EMPTY;
                        res_key_ff    <= '0;
                        if (head_valid_ff) begin
                           state_ff <= S_DUMP;
                        end else begin
                           state_ff <= S_EMIT;
                        end
                     end
                     MODE_REINIT: begin
                        res_status_ff <= ST_OK;
                        res_key_ff    <= req_key;
                        head_valid_ff <= 1'b0;
                        head_ff       <= '0;
                        free_head_ff  <= '0;
                        free_valid_ff <= 1'b1;
                        count_ff      <= '0;
                        state_ff      <= S_EMIT;
                     end
                     default: begin
                        res_status_ff <= ST_OK;
                        res_key_ff    <= req_key;
                        state_ff      <= S_EMIT;
                     end
                  endcase
               end
            end
            S_WALK: begin
               if (key_below) begin
                  prev_ff    <= cur_ff;
                  prev_ok_ff <= 1'b1;
                  cur_ff     <= link_q.idx;
                  cur_ok_ff  <= link_q.valid;
                  if (!link_q.valid) begin
                     state_ff <= S_DONE;
                  end
               end else begin
                  hit_ff      <= (key_q == key_ff);
                  cur_link_ff <= link_q;
                  state_ff    <= S_DONE;
               end
            end
            S_DONE: begin
               if (mode_ff == MODE_INSERT) begin
                  if (hit_ff) begin
                     res_status_ff <= ST_DUPLICATE;
                     res_slot_ff   <= SLOT_W'(cur_ff);
                     state_ff      <= S_EMIT;
                  end else begin
                     state_ff <= S_FREE;
                  end
               end else if (!hit_ff) begin
                  res_status_ff <= ST_NOT_FOUND;
                  state_ff      <= S_EMIT;
               end else begin
                  res_slot_ff <= SLOT_W'(cur_ff);
                  state_ff    <= (mode_ff == MODE_DELETE) ? S_UNLINK : S_EMIT;
               end
            end
            S_FREE: begin
               // link_q holds the free head's link: pop the slot
               new_ff        <= free_head_ff;
               free_head_ff  <= link_q.idx;
               free_valid_ff <= link_q.valid;
               count_ff      <= count_ff + COUNT_W'(1);
               res_slot_ff   <= SLOT_W'(free_head_ff);
               if (prev_ok_ff) begin
                  state_ff <= S_LINKP;
               end else begin
                  head_ff       <= free_head_ff;
                  head_valid_ff <= 1'b1;
                  state_ff      <= S_EMIT;
               end
            end
            S_LINKP: begin
               state_ff <= S_EMIT;
            end
            S_UNLINK: begin
               if (!prev_ok_ff) begin
                  head_ff       <= cur_link_ff.idx;
                  head_valid_ff <= cur_link_ff.valid;
               end
               state_ff <= S_RETURN;
            end
            S_RETURN: begin
               free_head_ff  <= cur_ff;
               free_valid_ff <= 1'b1;
               if (count_ff != '0) begin
                  count_ff <= count_ff - COUNT_W'(1);
               end
               state_ff <= S_EMIT;
            end
            S_DUMP: begin
               if (out_free) begin
                  rsp_status_ff <= ST_OK;
                  rsp_slot_ff   <= SLOT_W'(cur_ff);
                  rsp_key_ff    <= key_q;
                  rsp_count_ff  <= count_ff;
                  rsp_last_ff   <= !link_q.valid;
                  cur_ff        <= link_q.idx;
                  if (!link_q.valid) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_status_ff <= res_status_ff;
                  rsp_slot_ff   <= res_slot_ff;
                  rsp_key_ff    <= res_key_ff;
                  rsp_count_ff  <= count_ff;
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_slot    = rsp_slot_ff;
   assign rsp_key_out = rsp_key_ff;
   assign rsp_count   = rsp_count_ff;
   assign rsp_last    = rsp_last_ff;

endmodule
